/* rtl/core/nsg_pkg.sv */
// ----------------------------------------------------------------------------
// nsg_pkg: shared constants and types for the split gain block
// Widths, register codes and the divider cell record.
// ----------------------------------------------------------------------------
package nsg_pkg;

	localparam int SUM_W    = 40;              // histogram sum width
	localparam int GAIN_W   = 64;              // gain width
	localparam int SIDE_W   = SUM_W + 1;       // right-hand sums need one more bit
	localparam int MAG_W    = SIDE_W;          // |G|
	localparam int LO_W     = (MAG_W + 1) / 2; // squaring split
	localparam int HI_W     = MAG_W - LO_W;
	localparam int SQ_W     = 2 * MAG_W;       // G*G
	localparam int DIV_W    = SIDE_W + 1;      // 2*H
	localparam int REM_W    = DIV_W;
	localparam int Q_W      = GAIN_W;          // quotient bits kept
	localparam int EXT_W    = Q_W + REM_W;
	localparam int SIDE_LAT = 4 + Q_W;         // prep, multiply, sum, check, cells
	localparam int PIPE_LAT = SIDE_LAT + 2;    // plus two accumulate stages
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARENT   = 2'd0,
		REG_TOT_GRAD = 2'd1,
		REG_TOT_HESS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   bits;  // dividend bits out at top, quotient bits in at bottom
		logic [DIV_W-1:0] dvs;
		logic             ovf;
		logic             zero;
	} div_cell_t;

endpackage

/* rtl/core/nsg_if.sv */
// ----------------------------------------------------------------------------
// nsg_if: channel interfaces of the split gain block
// Bin input channel and gain result channel, valid/ready.
// ----------------------------------------------------------------------------
interface nsg_in_if import nsg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] left_grad_sum;
	logic signed [SUM_W-1:0] left_hess_sum;
	logic                    bin_last;

	modport src (output valid, left_grad_sum, left_hess_sum, bin_last, input ready);
	modport snk (input valid, left_grad_sum, left_hess_sum, bin_last, output ready);
endinterface

interface nsg_out_if import nsg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [GAIN_W-1:0] split_gain;
	logic                     gain_overflow;
	logic                     bin_last_out;

	modport src (output valid, split_gain, gain_overflow, bin_last_out, input ready);
	modport snk (input valid, split_gain, gain_overflow, bin_last_out, output ready);
endinterface

/* rtl/core/nsg_div_cell.sv */
// ----------------------------------------------------------------------------
// nsg_div_cell: one restoring division step
// Shifts one dividend bit into the remainder, yields one quotient bit.
// ----------------------------------------------------------------------------
module nsg_div_cell import nsg_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  div_cell_t cell_in,
	output div_cell_t cell_out
);
	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             qbit;
	div_cell_t        nxt;

	always_comb begin
		trial = {cell_in.rem, cell_in.bits[Q_W-1]};
		diff  = trial - {1'b0, cell_in.dvs};
		qbit  = (trial >= {1'b0, cell_in.dvs});
		nxt      = cell_in;
		nxt.rem  = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
		nxt.bits = {cell_in.bits[Q_W-2:0], qbit};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_out <= nxt;
		end
	end
endmodule

/* rtl/core/nsg_side.sv */
// ----------------------------------------------------------------------------
// nsg_side: magnitude of one side's term, floor(G*G / 2H)
// Split squaring, overflow check, then a chain of division cells.
// ----------------------------------------------------------------------------
module nsg_side import nsg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SIDE_W-1:0] g,
	input  logic [SIDE_W-1:0] h,
	output logic [Q_W-1:0]    term,
	output logic              ovf
);
	// stage a
	logic [MAG_W-1:0] mag_s1;
	logic [DIV_W-1:0] dvs_s1;
	logic             hneg_s1, hzero_s1, gnz_s1;
	// stage b
	logic [2*LO_W-1:0]      pll_s2;
	logic [LO_W+HI_W-1:0]   plh_s2;
	logic [2*HI_W-1:0]      phh_s2;
	logic [DIV_W-1:0]       dvs_s2;
	logic                   hneg_s2, hzero_s2, gnz_s2;
	// stage c
	logic [SQ_W-1:0]  sq_s3;
	logic [DIV_W-1:0] dvs_s3;
	logic             hneg_s3, hzero_s3, gnz_s3;
	// stage d
	div_cell_t        head_s4;
	logic [EXT_W-1:0] ext;
	logic [REM_W-1:0] top;

	div_cell_t chain [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= g[SIDE_W-1] ? (~g + 1'b1) : g;
			dvs_s1   <= {h, 1'b0};
			hneg_s1  <= h[SIDE_W-1];
			hzero_s1 <= (h == '0);
			gnz_s1   <= (g != '0);

			pll_s2   <= mag_s1[LO_W-1:0] * mag_s1[LO_W-1:0];
			plh_s2   <= mag_s1[LO_W-1:0] * mag_s1[MAG_W-1:LO_W];
			phh_s2   <= mag_s1[MAG_W-1:LO_W] * mag_s1[MAG_W-1:LO_W];
			dvs_s2   <= dvs_s1;
			hneg_s2  <= hneg_s1;
			hzero_s2 <= hzero_s1;
			gnz_s2   <= gnz_s1;

			sq_s3    <= (SQ_W'(phh_s2) << (2 * LO_W)) + (SQ_W'(plh_s2) << (LO_W + 1))
				+ SQ_W'(pll_s2);
			dvs_s3   <= dvs_s2;
			hneg_s3  <= hneg_s2;
			hzero_s3 <= hzero_s2;
			gnz_s3   <= gnz_s2;

			head_s4  <= '{rem: top, bits: ext[Q_W-1:0], dvs: dvs_s3,
				ovf: hzero_s3 ? gnz_s3 : (!hneg_s3 && (top >= dvs_s3)),
				zero: hneg_s3 | hzero_s3};
		end
	end

	// quotient fits the gain only if the part above it is below the divisor
	assign ext = EXT_W'(sq_s3);
	assign top = ext[EXT_W-1:Q_W];

	assign chain[0] = head_s4;

	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		nsg_div_cell u_cell (
			.clk      (clk),
			.en       (en),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	assign ovf  = chain[Q_W].ovf;
	assign term = (chain[Q_W].ovf | chain[Q_W].zero) ? '0 : chain[Q_W].bits;
endmodule

/* rtl/core/newton_split_gain_top.sv */
// ----------------------------------------------------------------------------
// newton_split_gain_top: split gain of one histogram bin boundary
// gain = parent_term + G_l^2/2H_l + G_r^2/2H_r, saturating.
// ----------------------------------------------------------------------------
// Stages: 4 (prep, multiply, sum, check), 64 division cells, 2 accumulate
//   stages, output buffer; the first stage loads on the accepting edge.
// Throughput: one bin per cycle while the output buffer is not full;
//   the 64-cell divider chain is fully pipelined.
// Reset (arst_n low, async): configuration registers cleared to zero,
//   pipeline and output buffer emptied.
module newton_split_gain_top import nsg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	nsg_in_if.snk                in_ch,
	nsg_out_if.src               out_ch
);
	// configuration registers
	logic [GAIN_W-1:0] parent_q;
	logic [SUM_W-1:0]  tot_grad_q;
	logic [SUM_W-1:0]  tot_hess_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_q   <= '0;
			tot_grad_q <= '0;
			tot_hess_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PARENT:   parent_q   <= cfg_data;
				REG_TOT_GRAD: tot_grad_q <= cfg_data[SUM_W-1:0];
				REG_TOT_HESS: tot_hess_q <= cfg_data[SUM_W-1:0];
				default: ; // unused index: write dropped
			endcase
		end
	end

	// The whole pipeline advances together. It stalls only when the
	// two-entry output buffer is full, so ready is a register decode.
	logic [1:0] cnt_q;
	logic       en;
	assign en          = (cnt_q != 2'd2);
	assign in_ch.ready = en;

	// side operands; right sums formed one bit wider so they never wrap
	logic [SIDE_W-1:0] gl, hl, gr, hr;
	assign gl = {in_ch.left_grad_sum[SUM_W-1], in_ch.left_grad_sum};
	assign hl = {in_ch.left_hess_sum[SUM_W-1], in_ch.left_hess_sum};
	assign gr = {tot_grad_q[SUM_W-1], tot_grad_q} - gl;
	assign hr = {tot_hess_q[SUM_W-1], tot_hess_q} - hl;

	logic [Q_W-1:0] tl, tr;
	logic           ovf_l, ovf_r;

	nsg_side u_left (
		.clk (clk), .en (en), .g (gl), .h (hl), .term (tl), .ovf (ovf_l)
	);
	nsg_side u_right (
		.clk (clk), .en (en), .g (gr), .h (hr), .term (tr), .ovf (ovf_r)
	);

	// valid and last-marker shift lines alongside the data path
	logic [PIPE_LAT-1:0] vld_q;
	logic [PIPE_LAT-1:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[PIPE_LAT-2:0], in_ch.bin_last};
		end
	end

	// accumulate: both terms are nonnegative, so only the upper bound matters
	logic [GAIN_W-1:0] acc_s1, tr_s1, gain_s2;
	logic              ovf_s1, ovf_s2;
	logic [GAIN_W-1:0] room1, room2;

	assign room1 = GAIN_MAX - parent_q;
	assign room2 = GAIN_MAX - acc_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1  <= parent_q + tl;
			tr_s1   <= tr;
			ovf_s1  <= ovf_l | ovf_r | (tl > room1);
			ovf_s2  <= ovf_s1 | (tr_s1 > room2);
			gain_s2 <= (ovf_s1 | (tr_s1 > room2)) ? GAIN_MAX : (acc_s1 + tr_s1);
		end
	end

	// two-entry output buffer
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              ovf;
		logic              last;
	} res_t;

	res_t buf_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic push, pop;

	assign push = en & vld_q[PIPE_LAT-1];
	assign pop  = out_ch.valid & out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= '{gain: gain_s2, ovf: ovf_s2, last: last_q[PIPE_LAT-1]};
		end
	end

	assign out_ch.valid         = (cnt_q != 2'd0);
	assign out_ch.split_gain    = buf_q[rd_ptr_q].gain;
	assign out_ch.gain_overflow = buf_q[rd_ptr_q].ovf;
	assign out_ch.bin_last_out  = buf_q[rd_ptr_q].last;
endmodule

/* rtl/core/nsg_checker.sv */
// ----------------------------------------------------------------------------
// nsg_checker: port-level checks of the split gain block
// Output buffer behavior and saturation consistency.
// ----------------------------------------------------------------------------
module nsg_checker import nsg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [GAIN_W-1:0] split_gain,
	input logic              gain_overflow
);
	// a full buffer always offers a result
	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid) else $error("stalled input with no result offered");

	// saturation flag goes with the maximum gain
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gain_overflow) |-> (split_gain == GAIN_MAX))
		else $error("overflow flagged without saturated gain");

	// a taken result frees room for input on the next cycle
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready) else $error("input not ready after pop");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(split_gain)
		&& $stable(gain_overflow))) else $error("stalled result changed");
endmodule

bind newton_split_gain_top nsg_checker u_nsg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.split_gain    (out_ch.split_gain),
	.gain_overflow (out_ch.gain_overflow)
);
